### sv/totp_pkg.sv
package totp_pkg;

    // Cycle counts of the division, compression and modulo phases.
    localparam int DIV_STEPS = 8;
    localparam int MOD_STEPS = 2;
    localparam int ROUNDS    = 80;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;

    // Block codes of the four SHA-1 compressions.
    localparam logic [1:0] BLK_IPAD  = 2'd0;
    localparam logic [1:0] BLK_CTR   = 2'd1;
    localparam logic [1:0] BLK_OPAD  = 2'd2;
    localparam logic [1:0] BLK_INNER = 2'd3;

    // SHA-1 initial hash value.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // Pad words and message length words of the second blocks.
    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5C5C5C5C;
    localparam logic [31:0] END_WORD  = 32'h80000000;
    localparam logic [31:0] LEN_CTR   = 32'd576;
    localparam logic [31:0] LEN_INNER = 32'd672;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       div_step;
        logic       load_blk;
        logic [1:0] blk;
        logic       round;
        logic [6:0] rnd;
        logic       finish;
        logic       trunc;
        logic       mod_step;
    } t_cmd;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        pow10 = p;
    endfunction

endpackage

### sv/totp_ctrl.sv
module totp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_valid,
    output totp_pkg::t_cmd  o_cmd
);
    import totp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_TRUNC = 3'd5;
    localparam logic [2:0] S_MOD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic [1:0] r_blk, n_blk;

    // Sequencing of division, four compressions, truncation and modulo.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_blk   = r_blk;
        o_cmd   = '0;
        o_cmd.blk = r_blk;
        o_cmd.rnd = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_item = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == 7'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_blk   = BLK_IPAD;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_LOAD: begin
                o_cmd.load_blk = 1'b1;
                n_cnt   = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_cnt == 7'(ROUNDS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                if (r_blk == BLK_INNER) begin
                    n_state = S_TRUNC;
                end else begin
                    n_blk   = r_blk + 2'd1;
                    n_state = S_LOAD;
                end
            end
            S_TRUNC: begin
                o_cmd.trunc = 1'b1;
                n_cnt   = '0;
                n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == 7'(MOD_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_blk   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_blk   <= n_blk;
        end
    end

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not start work");

    // The result strobe lasts exactly one cycle.
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held too long");

    // The round counter stays within the compression.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_cnt < 7'(ROUNDS))) else $error("round out of range");

endmodule

### sv/totp_dp.sv
module totp_dp #(
    parameter int TIME_STEP   = 30,
    parameter int CODE_DIGITS = 6
) (
    input  logic            i_clk,
    input  totp_pkg::t_cmd  i_cmd,
    input  logic [15:0]     i_key_high,
    input  logic [63:0]     i_key_low,
    input  logic [62:0]     i_unix_time,
    input  logic [19:0]     i_candidate_code,
    output logic            o_code_matches,
    output logic [19:0]     o_computed_code
);
    import totp_pkg::*;

    localparam longint MODULUS = pow10(CODE_DIGITS);

    // The time is divided one 16-bit digit at a time. Each partial dividend is
    // the running remainder (below TIME_STEP, so at most 12 bits) over a digit,
    // and its quotient comes from an exact multiply by a rounded-up reciprocal.
    localparam int          RW        = 12;
    localparam int          DIV_SHIFT = 28 + $clog2(TIME_STEP);
    localparam logic [28:0] DIV_MUL   = 29'(((longint'(1) << DIV_SHIFT)
                                         + longint'(TIME_STEP) - 1) / longint'(TIME_STEP));
    localparam logic [27:0] DIV_D     = 28'(TIME_STEP);

    // The 31-bit truncated value is reduced the same way, quotient first, then remainder.
    localparam int          MOD_SHIFT = 31 + $clog2(MODULUS);
    localparam logic [31:0] MOD_MUL   = 32'(((longint'(1) << MOD_SHIFT) + MODULUS - 1)
                                            / MODULUS);
    localparam logic [30:0] MOD_D     = 31'(MODULUS);

    // Time division and modulo units.
    logic [63:0]   r_time;
    logic [63:0]   r_q;
    logic [RW-1:0] r_drem;
    logic [27:0]   r_dcur;
    logic [15:0]   r_dq;
    logic [19:0]   r_cand;
    logic [30:0]   r_bin;
    logic [30:0]   r_mq;
    logic [30:0]   r_code;

    // SHA-1 state.
    logic [31:0] r_h [5];
    logic [31:0] r_inner [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];

    logic [27:0]    n_dcur;
    logic [56:0]    n_dprod;
    logic [27:0]    n_drem;
    logic [62:0]    n_mprod;
    logic [31:0]    n_f, n_k, n_t, n_wnew;
    logic [31:0]    n_sum [5];
    logic [31:0]    n_blkw [16];
    logic [63:0]    n_count;
    logic [159:0]   n_digest, n_shifted;
    logic [3:0]     n_off;

    // Reciprocal products and the digit remainder.
    always_comb begin
        n_dcur  = {r_drem, r_time[63:48]};
        n_dprod = {29'd0, n_dcur} * {28'd0, DIV_MUL};
        n_drem  = r_dcur - ({12'd0, r_dq} * DIV_D);
        n_mprod = {32'd0, r_bin} * {31'd0, MOD_MUL};
    end

    // Round function, constants and message schedule.
    always_comb begin
        if (i_cmd.rnd < 7'd20) begin
            n_f = (r_b & r_c) | (~r_b & r_d);
            n_k = 32'h5A827999;
        end else if (i_cmd.rnd < 7'd40) begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = 32'h6ED9EBA1;
        end else if (i_cmd.rnd < 7'd60) begin
            n_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            n_k = 32'h8F1BBCDC;
        end else begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = 32'hCA62C1D6;
        end
        n_t    = rotl(r_a, 5) + n_f + r_e + n_k + r_w[0];
        n_wnew = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
        n_sum[0] = r_h[0] + r_a;
        n_sum[1] = r_h[1] + r_b;
        n_sum[2] = r_h[2] + r_c;
        n_sum[3] = r_h[3] + r_d;
        n_sum[4] = r_h[4] + r_e;
    end

    // Words of the block to be compressed next.
    always_comb begin
        n_count = r_q;
        for (int i = 0; i < 16; i++) begin
            n_blkw[i] = '0;
        end
        case (i_cmd.blk)
            BLK_IPAD, BLK_OPAD: begin
                n_blkw[0] = {i_key_high, i_key_low[63:48]};
                n_blkw[1] = i_key_low[47:16];
                n_blkw[2] = {i_key_low[15:0], 16'h0000};
                for (int i = 0; i < 16; i++) begin
                    n_blkw[i] = n_blkw[i] ^
                        ((i_cmd.blk == BLK_IPAD) ? IPAD_WORD : OPAD_WORD);
                end
            end
            BLK_CTR: begin
                n_blkw[0]  = n_count[63:32];
                n_blkw[1]  = n_count[31:0];
                n_blkw[2]  = END_WORD;
                n_blkw[15] = LEN_CTR;
            end
            default: begin
                for (int i = 0; i < 5; i++) begin
                    n_blkw[i] = r_inner[i];
                end
                n_blkw[5]  = END_WORD;
                n_blkw[15] = LEN_INNER;
            end
        endcase
    end

    // Dynamic truncation of the outer digest.
    always_comb begin
        n_digest  = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
        n_off     = n_digest[3:0];
        n_shifted = n_digest << {n_off, 3'b000};
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_time <= {1'b0, i_unix_time};
            r_drem <= '0;
            r_cand <= i_candidate_code;
            r_h[0] <= IV0;
            r_h[1] <= IV1;
            r_h[2] <= IV2;
            r_h[3] <= IV3;
            r_h[4] <= IV4;
        end
        // Even steps estimate a quotient digit, odd steps settle the remainder.
        if (i_cmd.div_step) begin
            if (!i_cmd.rnd[0]) begin
                r_dcur <= n_dcur;
                r_dq   <= 16'(n_dprod >> DIV_SHIFT);
            end else begin
                r_drem <= n_drem[RW-1:0];
                r_q    <= {r_q[47:0], r_dq};
                r_time <= {r_time[47:0], 16'h0000};
            end
        end
        if (i_cmd.load_blk) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= n_blkw[i];
            end
        end
        if (i_cmd.round) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= rotl(r_b, 30);
            r_b <= r_a;
            r_a <= n_t;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_wnew;
        end
        if (i_cmd.finish) begin
            // The inner digest is set aside and the outer hash restarts.
            if (i_cmd.blk == BLK_CTR) begin
                for (int i = 0; i < 5; i++) begin
                    r_inner[i] <= n_sum[i];
                end
                r_h[0] <= IV0;
                r_h[1] <= IV1;
                r_h[2] <= IV2;
                r_h[3] <= IV3;
                r_h[4] <= IV4;
            end else begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= n_sum[i];
                end
            end
        end
        if (i_cmd.trunc) begin
            r_bin <= n_shifted[158:128];
        end
        // The first modulo step forms the quotient, the second the remainder.
        if (i_cmd.mod_step) begin
            if (!i_cmd.rnd[0]) begin
                r_mq <= 31'(n_mprod >> MOD_SHIFT);
            end else begin
                r_code <= r_bin - r_mq * MOD_D;
            end
        end
    end

    // Result fields; the comparison uses the full code.
    assign o_computed_code = r_code[19:0];
    assign o_code_matches  = (r_code == {11'd0, r_cand});

endmodule

### sv/totp_hmac_sha1_checker_core.sv
// Channel   Handshake            Payload
// input     start, busy          i_unix_time, i_candidate_code
// result    o_valid (strobe)     o_code_matches, o_computed_code
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// An item passes time division (four 16-bit digits, each estimated then
// settled), four SHA-1 compressions on one round unit (each a block load, the
// rounds and a finishing add), truncation, the modulo steps (quotient, then
// remainder) and the strobe. busy stays high through the strobe, so a new item
// is taken only after it. Reset is synchronous and active low; it clears the
// controller and the key. The receiver cannot stall the result.
module totp_hmac_sha1_checker_core #(
    parameter int TIME_STEP   = 30,
    parameter int CODE_DIGITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [62:0] i_unix_time,
    input  logic [19:0] i_candidate_code,
    output logic        o_valid,
    output logic        o_code_matches,
    output logic [19:0] o_computed_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import totp_pkg::*;

    logic [15:0] r_key_high;
    logic [63:0] r_key_low;
    t_cmd        cmd;

    // Key registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data[15:0];
            end else if (i_cfg_idx == REG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
        end
    end

    totp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    totp_dp #(
        .TIME_STEP   (TIME_STEP),
        .CODE_DIGITS (CODE_DIGITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_key_high       (r_key_high),
        .i_key_low        (r_key_low),
        .i_unix_time      (i_unix_time),
        .i_candidate_code (i_candidate_code),
        .o_code_matches   (o_code_matches),
        .o_computed_code  (o_computed_code)
    );

endmodule
